// ===== sv/cbd_pkg.sv =====
`default_nettype none

package cbd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       chunk_end;
    logic       done_res;
    logic [2:0] status;
  } out_beat_t;

  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_VT  = 8'h0B;
  localparam logic [7:0] CHAR_FF  = 8'h0C;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;

  // Status codes reported on the final beat of a buffer.
  localparam logic [2:0] ST_ZERO         = 3'd0;
  localparam logic [2:0] ST_BETWEEN      = 3'd1;
  localparam logic [2:0] ST_NO_SIZE_CRLF = 3'd2;
  localparam logic [2:0] ST_IN_DATA      = 3'd3;
  localparam logic [2:0] ST_NO_DATA_CRLF = 3'd4;

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SP) || (c == CHAR_TAB) || (c == CHAR_LF) ||
           (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
  endfunction

endpackage

`default_nettype wire

// ===== sv/cbd_in_stage.sv =====
`default_nettype none

module cbd_in_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             enc_valid,
  output logic                  enc_ready,
  input  wire cbd_pkg::in_beat_t enc_beat,
  input  wire logic             advance,
  output logic                  hold_valid,
  output cbd_pkg::in_beat_t     hold_beat
);

  assign enc_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (enc_valid && enc_ready) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (enc_valid && enc_ready) begin
      hold_beat <= enc_beat;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbd_parser.sv =====
`default_nettype none

module cbd_parser #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cbd_pkg::in_beat_t beat,
  input  wire logic              take,
  output cbd_pkg::out_beat_t     res,
  output logic                   res_valid
);

  typedef enum logic [2:0] {
    PH_START, PH_LEAD, PH_DIGITS, PH_IGNORE,
    PH_DATA, PH_DATA_CR, PH_DATA_LF, PH_STOP
  } phase_t;

  phase_t               phase, phase_next, phase_cr;
  logic [SIZE_BITS-1:0] size_accum, size_accum_next, size_digit;
  logic [SIZE_BITS-1:0] bytes_left, bytes_left_next;
  logic                 cr_pending, cr_pending_next;
  logic [2:0]           final_status, final_status_next;
  logic                 hit, cend;
  logic [2:0]           st;
  logic [4:0]           hx;
  logic [7:0]           c;
  logic                 next_in_size_line;

  assign c  = beat.data_byte;
  assign hx = cbd_pkg::hex_decode(c);

  // Shifting in a nibble saturates once any of the top four bits is set.
  assign size_digit = (|size_accum[SIZE_BITS-1 -: 4]) ? {SIZE_BITS{1'b1}}
                                                      : {size_accum[SIZE_BITS-5:0], hx[3:0]};

  // A pending CR not followed by LF acts as a blank of the size line.
  always_comb begin
    phase_cr = phase;
    if (cr_pending) begin
      unique case (phase)
        PH_START, PH_LEAD: phase_cr = PH_LEAD;
        PH_DIGITS:         phase_cr = PH_IGNORE;
        default:           phase_cr = phase;
      endcase
    end
  end

  always_comb begin
    phase_next        = phase;
    size_accum_next   = size_accum;
    bytes_left_next   = bytes_left;
    cr_pending_next   = cr_pending;
    final_status_next = final_status;
    hit               = 1'b0;
    cend              = 1'b0;
    unique case (phase)
      PH_START, PH_LEAD, PH_DIGITS, PH_IGNORE: begin
        if (cr_pending && c == cbd_pkg::CHAR_LF) begin
          cr_pending_next = 1'b0;
          if (size_accum == '0) begin
            phase_next        = PH_STOP;
            final_status_next = cbd_pkg::ST_ZERO;
          end else begin
            bytes_left_next = size_accum;
            size_accum_next = '0;
            phase_next      = PH_DATA;
          end
        end else begin
          cr_pending_next = (c == cbd_pkg::CHAR_CR);
          phase_next      = phase_cr;
          if (c != cbd_pkg::CHAR_CR) begin
            unique case (phase_cr)
              PH_START, PH_LEAD: begin
                if (cbd_pkg::is_blank(c)) begin
                  phase_next = PH_LEAD;
                end else if (hx[4]) begin
                  phase_next      = PH_DIGITS;
                  size_accum_next = size_digit;
                end else begin
                  phase_next = PH_IGNORE;
                end
              end
              PH_DIGITS: begin
                if (hx[4]) begin
                  size_accum_next = size_digit;
                end else begin
                  phase_next = PH_IGNORE;
                end
              end
              default: phase_next = phase_cr;
            endcase
          end
        end
      end
      PH_DATA: begin
        hit = 1'b1;
        if (~|bytes_left[SIZE_BITS-1:1]) begin
          bytes_left_next = '0;
          cend            = 1'b1;
          phase_next      = PH_DATA_CR;
        end else begin
          bytes_left_next = bytes_left - SIZE_BITS'(1);
        end
      end
      PH_DATA_CR: begin
        if (c == cbd_pkg::CHAR_CR) begin
          phase_next = PH_DATA_LF;
        end else begin
          phase_next        = PH_STOP;
          final_status_next = cbd_pkg::ST_NO_DATA_CRLF;
        end
      end
      PH_DATA_LF: begin
        if (c == cbd_pkg::CHAR_LF) begin
          phase_next = PH_START;
        end else begin
          phase_next        = PH_STOP;
          final_status_next = cbd_pkg::ST_NO_DATA_CRLF;
        end
      end
      default: phase_next = phase;
    endcase
  end

  assign next_in_size_line = (phase_next == PH_START) || (phase_next == PH_LEAD) ||
                             (phase_next == PH_DIGITS) || (phase_next == PH_IGNORE);

  always_comb begin
    st = cbd_pkg::ST_ZERO;
    if (beat.last_byte) begin
      priority if (phase_next == PH_STOP) begin
        st = final_status_next;
      end else if (phase_next == PH_START && !cr_pending_next) begin
        st = cbd_pkg::ST_BETWEEN;
      end else if (next_in_size_line) begin
        st = cbd_pkg::ST_NO_SIZE_CRLF;
      end else if (phase_next == PH_DATA) begin
        st = cbd_pkg::ST_IN_DATA;
      end else begin
        st = cbd_pkg::ST_NO_DATA_CRLF;
      end
    end
  end

  assign res.out_byte   = hit ? c : 8'd0;
  assign res.byte_valid = hit;
  assign res.chunk_end  = cend;
  assign res.done_res   = beat.last_byte;
  assign res.status     = st;
  assign res_valid      = hit || beat.last_byte;

  // The final beat of a buffer returns the parser to its reset state.
  always_ff @(posedge clk) begin
    if (rst || (take && beat.last_byte)) begin
      phase        <= PH_START;
      size_accum   <= '0;
      bytes_left   <= '0;
      cr_pending   <= 1'b0;
      final_status <= cbd_pkg::ST_ZERO;
    end else if (take) begin
      phase        <= phase_next;
      size_accum   <= size_accum_next;
      bytes_left   <= bytes_left_next;
      cr_pending   <= cr_pending_next;
      final_status <= final_status_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbd_out_stage.sv =====
`default_nettype none

module cbd_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire cbd_pkg::out_beat_t load_beat,
  output logic                    can_load,
  output logic                    dec_valid,
  input  wire logic               dec_ready,
  output cbd_pkg::out_beat_t      dec_beat
);

  assign can_load = !dec_valid || dec_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (load) begin
      dec_valid <= 1'b1;
    end else if (dec_ready) begin
      dec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dec_beat <= load_beat;
    end
  end

endmodule

`default_nettype wire

// ===== sv/chunked_body_decoder.sv =====
// Chunked body decoder.
// Encoded bytes enter on the enc channel, one beat per byte, with last_byte
// set on the final byte of a buffer. Decoded results leave on the dec
// channel: a beat for every chunk data byte (chunk_end marks the last byte of
// each chunk) and a beat for the final byte of a buffer, which carries
// done_res and the status. Size-line and trailer bytes produce no beat.
// Each accepted byte waits in the input holding register, where the parser
// decodes it combinationally; its result is loaded into the output register
// as soon as the output register can take it.
// Throughput: one byte per cycle while the receiver keeps up, through the
// combinational parser update between the input and output registers.
// Reset clears the valid flags of both registers and the parser state; the
// final byte of a buffer also returns the parser to its reset state.
// When the receiver stalls, the output register holds its beat; bytes that
// produce no result keep flowing, and the first byte that needs the output
// waits in the input register, after which enc_ready drops.
// SIZE_BITS sets the width of the chunk size counter (8 to 64); larger sizes
// saturate at the counter maximum.
`default_nettype none

module chunked_body_decoder #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               enc_valid,
  output logic                    enc_ready,
  input  wire cbd_pkg::in_beat_t  enc_beat,
  output logic                    dec_valid,
  input  wire logic               dec_ready,
  output cbd_pkg::out_beat_t      dec_beat
);

  logic               hold_valid;
  cbd_pkg::in_beat_t  hold_beat;
  cbd_pkg::out_beat_t res;
  logic               res_valid;
  logic               can_load;
  logic               advance;

  assign advance = hold_valid && (!res_valid || can_load);

  cbd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .enc_valid  (enc_valid),
    .enc_ready  (enc_ready),
    .enc_beat   (enc_beat),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_beat  (hold_beat)
  );

  cbd_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .beat      (hold_beat),
    .take      (advance),
    .res       (res),
    .res_valid (res_valid)
  );

  cbd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .load_beat (res),
    .can_load  (can_load),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_beat  (dec_beat)
  );

endmodule

`default_nettype wire

// ===== sv/cbd_checker.sv =====
`default_nettype none

module cbd_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               dec_valid,
  input wire logic               dec_ready,
  input wire cbd_pkg::out_beat_t dec_beat
);

  // A stalled result beat holds.
  a_dec_hold: assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec_ready |=> dec_valid && $stable(dec_beat))
    else $error("dec beat changed while stalled");

  // Every result beat carries either a data byte or the buffer status.
  a_beat_kind: assert property (@(posedge clk) disable iff (rst)
    dec_valid |-> dec_beat.byte_valid || dec_beat.done_res)
    else $error("empty dec beat");

  a_no_data_zero: assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec_beat.byte_valid |-> dec_beat.out_byte == 8'd0 && !dec_beat.chunk_end)
    else $error("non-data beat carries a byte or chunk end");

  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec_beat.done_res |-> dec_beat.status == cbd_pkg::ST_ZERO)
    else $error("status set without done");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    dec_valid && dec_beat.done_res |->
      dec_beat.status == cbd_pkg::ST_ZERO || dec_beat.status == cbd_pkg::ST_BETWEEN ||
      dec_beat.status == cbd_pkg::ST_NO_SIZE_CRLF || dec_beat.status == cbd_pkg::ST_IN_DATA ||
      dec_beat.status == cbd_pkg::ST_NO_DATA_CRLF)
    else $error("unknown status code");

endmodule

bind chunked_body_decoder cbd_checker u_cbd_checker (
  .clk       (clk),
  .rst       (rst),
  .dec_valid (dec_valid),
  .dec_ready (dec_ready),
  .dec_beat  (dec_beat)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
module tb_top;

  localparam int SIZE_BITS      = 32;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int QUIET_TAIL     = 150;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

  typedef enum logic [2:0] {
    P_START, P_LEAD, P_DIGITS, P_IGNORE, P_DATA, P_DATA_CR, P_DATA_LF, P_STOP
  } parse_phase_t;

  logic               clk;
  logic               rst       = 1'b1;
  logic               enc_valid = 1'b0;
  logic               enc_ready;
  cbd_pkg::in_beat_t  enc_beat  = '0;
  logic               dec_valid;
  logic               dec_ready = 1'b0;
  cbd_pkg::out_beat_t dec_beat;

  chunked_body_decoder #(.SIZE_BITS(SIZE_BITS)) DUT (.*);

  // Decoder model state.
  parse_phase_t         pr_phase;
  logic [SIZE_BITS-1:0] pr_size;
  logic [SIZE_BITS-1:0] pr_left;
  logic                 pr_cr;
  logic [2:0]           pr_status;

  logic [7:0]         body_q[$];
  cbd_pkg::in_beat_t  pending_q[$];
  cbd_pkg::out_beat_t expected_q[$];

  int total_items  = 0;
  int buffers_sent = 0;
  int items_in     = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int stall_cnt    = 0;
  int cycle_cnt    = 0;
  int send_gap     = 0;
  int recv_gap     = 0;
  int status_seen[8];
  logic calm       = 1'b0;
  logic quiet_tail = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_parser();
    pr_phase  = P_START;
    pr_size   = '0;
    pr_left   = '0;
    pr_cr     = 1'b0;
    pr_status = cbd_pkg::ST_ZERO;
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - "0";
    if (c >= "a" && c <= "f") return int'(c) - "a" + 10;
    if (c >= "A" && c <= "F") return int'(c) - "A" + 10;
    return -1;
  endfunction

  // The size counter saturates instead of wrapping.
  function automatic void push_size_digit(input int d);
    if (pr_size > (SIZE_MAX >> 4)) begin
      pr_size = SIZE_MAX;
    end else begin
      pr_size = {pr_size[SIZE_BITS-5:0], 4'(d)};
    end
  endfunction

  function automatic void size_line_char(input logic [7:0] c);
    int   h;
    logic blank;
    h     = hex_nibble(c);
    blank = (c == cbd_pkg::CHAR_SP) || (c == cbd_pkg::CHAR_TAB) ||
            (c == cbd_pkg::CHAR_LF) || (c == cbd_pkg::CHAR_VT) ||
            (c == cbd_pkg::CHAR_FF) || (c == cbd_pkg::CHAR_CR);
    case (pr_phase)
      P_START, P_LEAD: begin
        if (blank) begin
          pr_phase = P_LEAD;
        end else if (h >= 0) begin
          pr_phase = P_DIGITS;
          push_size_digit(h);
        end else begin
          pr_phase = P_IGNORE;
        end
      end
      P_DIGITS: begin
        if (h >= 0) begin
          push_size_digit(h);
        end else begin
          pr_phase = P_IGNORE;
        end
      end
      default: ;
    endcase
  endfunction

  // Advances the model by one encoded byte; returns 1 when a result beat is due.
  function automatic logic decode_beat(input cbd_pkg::in_beat_t ib,
                                       output cbd_pkg::out_beat_t ob);
    logic       passed;
    logic       ends;
    logic [2:0] st;
    passed = 1'b0;
    ends   = 1'b0;
    st     = cbd_pkg::ST_ZERO;
    case (pr_phase)
      P_START, P_LEAD, P_DIGITS, P_IGNORE: begin
        if (pr_cr && ib.data_byte == cbd_pkg::CHAR_LF) begin
          pr_cr = 1'b0;
          if (pr_size == '0) begin
            pr_phase  = P_STOP;
            pr_status = cbd_pkg::ST_ZERO;
          end else begin
            pr_left  = pr_size;
            pr_size  = '0;
            pr_phase = P_DATA;
          end
        end else begin
          // A CR held back from the previous byte was not part of CR LF.
          if (pr_cr) size_line_char(cbd_pkg::CHAR_CR);
          if (ib.data_byte == cbd_pkg::CHAR_CR) begin
            pr_cr = 1'b1;
          end else begin
            pr_cr = 1'b0;
            size_line_char(ib.data_byte);
          end
        end
      end
      P_DATA: begin
        passed = 1'b1;
        if (pr_left <= 1) begin
          pr_left  = '0;
          ends     = 1'b1;
          pr_phase = P_DATA_CR;
        end else begin
          pr_left = pr_left - 1'b1;
        end
      end
      P_DATA_CR: begin
        if (ib.data_byte == cbd_pkg::CHAR_CR) begin
          pr_phase = P_DATA_LF;
        end else begin
          pr_phase  = P_STOP;
          pr_status = cbd_pkg::ST_NO_DATA_CRLF;
        end
      end
      P_DATA_LF: begin
        if (ib.data_byte == cbd_pkg::CHAR_LF) begin
          pr_phase = P_START;
        end else begin
          pr_phase  = P_STOP;
          pr_status = cbd_pkg::ST_NO_DATA_CRLF;
        end
      end
      default: ;
    endcase
    if (ib.last_byte) begin
      if (pr_phase == P_STOP) begin
        st = pr_status;
      end else if (pr_phase == P_START && !pr_cr) begin
        st = cbd_pkg::ST_BETWEEN;
      end else if (pr_phase <= P_IGNORE) begin
        st = cbd_pkg::ST_NO_SIZE_CRLF;
      end else if (pr_phase == P_DATA) begin
        st = cbd_pkg::ST_IN_DATA;
      end else begin
        st = cbd_pkg::ST_NO_DATA_CRLF;
      end
    end
    ob.out_byte   = passed ? ib.data_byte : 8'h00;
    ob.byte_valid = passed;
    ob.chunk_end  = ends;
    ob.done_res   = ib.last_byte;
    ob.status     = st;
    if (ib.last_byte) clear_parser();
    return passed || ib.last_byte;
  endfunction

  function automatic void check_beat(input cbd_pkg::out_beat_t want,
                                     input cbd_pkg::out_beat_t got);
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, got.out_byte);
      mismatches++;
    end
    if (got.byte_valid !== want.byte_valid) begin
      $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
      mismatches++;
    end
    if (got.chunk_end !== want.chunk_end) begin
      $error("chunk_end: expected %0b, got %0b", want.chunk_end, got.chunk_end);
      mismatches++;
    end
    if (got.done_res !== want.done_res) begin
      $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
  endfunction

  // ---------------- stimulus building ----------------

  function automatic void put_byte(input logic [7:0] c);
    body_q.insert(body_q.size(), c);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void add_crlf();
    put_byte(cbd_pkg::CHAR_CR);
    put_byte(cbd_pkg::CHAR_LF);
  endfunction

  function automatic logic [7:0] any_byte_except(input logic [7:0] bad);
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == bad) c = ~c;
    return c;
  endfunction

  function automatic logic [7:0] lead_blank();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = cbd_pkg::CHAR_SP;
      1:       c = cbd_pkg::CHAR_TAB;
      2:       c = cbd_pkg::CHAR_LF;
      3:       c = cbd_pkg::CHAR_VT;
      4:       c = cbd_pkg::CHAR_FF;
      default: c = cbd_pkg::CHAR_CR;
    endcase
    // CR then LF would end the line instead of being two blanks.
    if (c == cbd_pkg::CHAR_LF && body_q.size() > 0 && body_q[$] == cbd_pkg::CHAR_CR) begin
      c = cbd_pkg::CHAR_SP;
    end
    return c;
  endfunction

  function automatic void add_size_line(input int unsigned sz);
    string      digits;
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) put_byte(lead_blank());
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put_byte("0");
    digits = $sformatf("%0h", sz);
    for (int i = 0; i < digits.len(); i++) begin
      c = digits[i];
      if (c >= "a" && c <= "f" && $urandom_range(0, 1) == 1) c = c - 8'h20;
      put_byte(c);
    end
    if ($urandom_range(0, 4) == 0) begin
      put_byte(";");
      repeat ($urandom_range(0, 6)) put_byte(any_byte_except(cbd_pkg::CHAR_CR));
    end
    add_crlf();
  endfunction

  function automatic void add_data(input int unsigned sz);
    repeat (sz) put_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic int unsigned pick_size();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
  endfunction

  function automatic void flush_buffer();
    cbd_pkg::in_beat_t ib;
    foreach (body_q[i]) begin
      ib.data_byte = body_q[i];
      ib.last_byte = (i == body_q.size() - 1);
      pending_q.insert(pending_q.size(), ib);
    end
    body_q.delete();
    buffers_sent++;
  endfunction

  // Mostly well-formed bodies with random content; the rest are cut short,
  // corrupted, or plain noise.
  function automatic void add_random_buffer();
    int          kind;
    int          ending;
    int          cut;
    int unsigned sz;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 16)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 4)) begin
        sz = pick_size();
        add_size_line(sz);
        add_data(sz);
        add_crlf();
      end
      ending = $urandom_range(0, 9);
      if (ending < 5) begin
        add_size_line(0);
        repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)));
      end else if (ending < 7) begin
        if (body_q.size() == 0) put_byte(lead_blank());
      end else if (ending < 9) begin
        sz = pick_size();
        add_size_line(sz);
        add_data(sz);
        cut = $urandom_range(1, body_q.size());
        while (body_q.size() > cut) void'(body_q.pop_back());
      end else begin
        sz = pick_size();
        add_size_line(sz);
        add_data(sz);
        if ($urandom_range(0, 1) == 1) begin
          put_byte(cbd_pkg::CHAR_CR);
          put_byte(any_byte_except(cbd_pkg::CHAR_LF));
        end else begin
          put_byte(any_byte_except(cbd_pkg::CHAR_CR));
        end
        repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) begin
        body_q[$urandom_range(0, body_q.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end
    flush_buffer();
  endfunction

  // ---------------- driver, receiver, checker ----------------

  always @(posedge clk) begin
    if (cycle_cnt % 97 == 0) calm <= ($urandom_range(0, 2) == 0);
    cycle_cnt <= cycle_cnt + 1;
  end

  always @(posedge clk) begin
    if (rst) begin
      enc_valid <= 1'b0;
    end else if (!enc_valid || enc_ready) begin
      if (send_gap > 0) begin
        send_gap  = send_gap - 1;
        enc_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        enc_beat  <= pending_q.pop_front();
        enc_valid <= 1'b1;
        if (!calm && !quiet_tail && $urandom_range(0, 6) == 0) send_gap = $urandom_range(1, 10);
      end else begin
        enc_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      dec_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap  = recv_gap - 1;
      dec_ready <= 1'b0;
    end else if (!calm && !quiet_tail && $urandom_range(0, 9) == 0) begin
      recv_gap  = $urandom_range(1, 10) - 1;
      dec_ready <= 1'b0;
    end else begin
      dec_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cbd_pkg::out_beat_t want;
    logic               moved;
    if (rst) begin
      clear_parser();
    end else begin
      moved = (enc_valid && enc_ready) || (dec_valid && dec_ready);
      if (enc_valid && enc_ready) begin
        items_in <= items_in + 1;
        if (decode_beat(enc_beat, want)) expected_q.insert(expected_q.size(), want);
      end
      if (dec_valid && dec_ready) begin
        results_seen <= results_seen + 1;
        if (dec_beat.done_res) status_seen[dec_beat.status]++;
        if (expected_q.size() == 0) begin
          $error("unexpected result beat %p", dec_beat);
          mismatches++;
        end else begin
          check_beat(expected_q.pop_front(), dec_beat);
        end
      end
      stall_cnt  <= moved ? 0 : stall_cnt + 1;
      quiet_tail <= (total_items - items_in) < QUIET_TAIL;
    end
  end

  initial begin
    while (stall_cnt < STALL_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    // Blanks and a lone CR before the size, a lone CR after it, one 0xFF byte.
    put_byte(cbd_pkg::CHAR_VT);
    put_byte(cbd_pkg::CHAR_CR);
    add_text("1");
    put_byte(cbd_pkg::CHAR_CR);
    add_text("q");
    add_crlf();
    put_byte(8'hFF);
    add_crlf();
    flush_buffer();
    // A hex prefix reads as size zero; the final 0x00 byte is ignored.
    add_text("0x1a");
    add_crlf();
    put_byte(8'h00);
    flush_buffer();
    // Saturating size, then the buffer ends inside the chunk.
    repeat (9) put_byte("F");
    add_crlf();
    add_text("z");
    flush_buffer();
    // Only blanks before the end.
    put_byte(cbd_pkg::CHAR_SP);
    put_byte(cbd_pkg::CHAR_TAB);
    flush_buffer();
    // Empty size line.
    put_byte(cbd_pkg::CHAR_FF);
    add_crlf();
    flush_buffer();

    total_items = pending_q.size() + RANDOM_ITEMS;
    while (pending_q.size() < total_items) add_random_buffer();
    total_items = pending_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (items_in < total_items) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d buffers (%0d encoded bytes) and checked %0d result beats.",
             buffers_sent, items_in, results_seen);
    $display("End status counts: zero %0d, between %0d, size line %0d, data %0d, trailer %0d.",
             status_seen[cbd_pkg::ST_ZERO], status_seen[cbd_pkg::ST_BETWEEN],
             status_seen[cbd_pkg::ST_NO_SIZE_CRLF], status_seen[cbd_pkg::ST_IN_DATA],
             status_seen[cbd_pkg::ST_NO_DATA_CRLF]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
